@@ rtl/bdt_pkg.sv @@
// Shared types, constants and the span join for the bracket depth tracker.
// No dependencies; used by the top level.
`default_nettype none

package bdt_pkg;

   // Line geometry; the tree pads the leaves up to a power of two
   localparam int LENGTH     = 1048576;
   localparam int CUR_W      = $clog2(LENGTH);
   localparam int IDX_W      = CUR_W + 1;
   localparam int TREE_DEPTH = 2 ** IDX_W;
   localparam int VAL_W      = 22;
   localparam int NODE_W     = 3 * VAL_W;

   localparam logic [CUR_W-1:0] CURSOR_MAX = CUR_W'(LENGTH - 1);

   // Command bytes
   localparam logic [7:0] SYM_OPEN  = 8'h28;
   localparam logic [7:0] SYM_CLOSE = 8'h29;
   localparam logic [7:0] SYM_LEFT  = 8'h4C;
   localparam logic [7:0] SYM_RIGHT = 8'h52;

   // One tree node: sum, lowest prefix and highest prefix of its span
   typedef struct packed {
      logic signed [VAL_W-1:0] total;
      logic signed [VAL_W-1:0] lowest;
      logic signed [VAL_W-1:0] highest;
   } node_type;

   function automatic logic signed [VAL_W-1:0] sym_weight(input logic [7:0] sym);
      logic signed [VAL_W-1:0] w;
      case (sym)
         SYM_OPEN:  w = VAL_W'(1);
         SYM_CLOSE: w = '1;
         default:   w = '0;
      endcase
      return w;
   endfunction

   // Combine a left span and a right span
   function automatic node_type join_span(input node_type lo, input node_type hi);
      node_type                r;
      logic signed [VAL_W-1:0] rmin;
      logic signed [VAL_W-1:0] rmax;
      rmin      = lo.total + hi.lowest;
      rmax      = lo.total + hi.highest;
      r.total   = lo.total + hi.total;
      r.lowest  = (lo.lowest < rmin) ? lo.lowest : rmin;
      r.highest = (lo.highest > rmax) ? lo.highest : rmax;
      return r;
   endfunction

endpackage

`default_nettype wire

@@ rtl/bdt_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module bdt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

@@ rtl/bracket_editor_depth_tracker.sv @@
// Bracket editor depth tracker top level: cursor, sequencer and segment tree.
// Depends on bdt_pkg and bdt_ram.
//
// Each input word is one editor command; each produces exactly one result word
// with the maximum nesting depth of the whole line, or -1 when the line is not
// balanced. The balance is kept in a segment tree held in one RAM with one write
// and one registered read port. After reset the block first clears that RAM,
// one node per cycle; req_stall stays high until then. Afterwards 'L' and 'R'
// go straight to the result, and a write that leaves the cell kind unchanged
// stops after the leaf read; a write that changes a cell reads the leaf, then
// walks up one tree level per cycle (sibling read and parent write overlap)
// up to the root. A result that waits in the output register does not block
// the next command from entering.
`default_nettype none

module bracket_editor_depth_tracker (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire logic [7:0]                         req_symbol,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output logic signed [bdt_pkg::VAL_W-1:0]        rsp_depth_or_fail
);

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_LEAF  = 3'd2;
   localparam logic [2:0] ST_WALK  = 3'd3;
   localparam logic [2:0] ST_DONE  = 3'd4;

   logic [2:0]                        state_ff,    state_in;
   logic [bdt_pkg::CUR_W-1:0]         cursor_ff,   cursor_in;
   logic [bdt_pkg::IDX_W-1:0]         clear_ff,    clear_in;
   logic [bdt_pkg::IDX_W-1:0]         node_idx_ff, node_idx_in;
   logic signed [bdt_pkg::VAL_W-1:0]  weight_ff,   weight_in;
   bdt_pkg::node_type                 cur_ff,      cur_in;
   bdt_pkg::node_type                 root_ff,     root_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic signed [bdt_pkg::VAL_W-1:0]  rsp_data_ff,  rsp_data_in;

   logic                              ram_we;
   logic [bdt_pkg::IDX_W-1:0]         ram_waddr;
   logic [bdt_pkg::NODE_W-1:0]        ram_wdata;
   logic                              ram_re;
   logic [bdt_pkg::IDX_W-1:0]         ram_raddr;
   logic [bdt_pkg::NODE_W-1:0]        ram_rdata;

   bdt_pkg::node_type                 rd_node;
   bdt_pkg::node_type                 leaf_node;
   bdt_pkg::node_type                 parent;
   logic [bdt_pkg::IDX_W-1:0]         leaf_idx;
   logic [bdt_pkg::IDX_W-1:0]         par_idx;
   logic signed [bdt_pkg::VAL_W-1:0]  answer;

   // Tree storage
   bdt_ram #(
      .WIDTH (bdt_pkg::NODE_W),
      .DEPTH (bdt_pkg::TREE_DEPTH)
   ) u_tree (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // Node helpers
   assign rd_node   = bdt_pkg::node_type'(ram_rdata);
   assign leaf_idx  = {1'b1, cursor_ff};
   assign leaf_node = '{total: weight_ff, lowest: weight_ff, highest: weight_ff};
   assign par_idx   = node_idx_ff >> 1;
   assign parent    = node_idx_ff[0] ? bdt_pkg::join_span(rd_node, cur_ff)
                                     : bdt_pkg::join_span(cur_ff, rd_node);

   // Line verdict from the root
   assign answer = (root_ff.total == '0 && !root_ff.lowest[bdt_pkg::VAL_W-1])
                   ? root_ff.highest : '1;

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      cursor_in    = cursor_ff;
      clear_in     = clear_ff;
      node_idx_in  = node_idx_ff;
      weight_in    = weight_ff;
      cur_in       = cur_ff;
      root_in      = root_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      ram_we       = 1'b0;
      ram_waddr    = '0;
      ram_wdata    = '0;
      ram_re       = 1'b0;
      ram_raddr    = '0;

      case (state_ff)
         ST_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = clear_ff;
            clear_in  = clear_ff + bdt_pkg::IDX_W'(1);
            if (clear_ff == '1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               if (req_symbol == bdt_pkg::SYM_LEFT) begin
                  if (cursor_ff != '0) begin
                     cursor_in = cursor_ff - bdt_pkg::CUR_W'(1);
                  end
                  state_in = ST_DONE;
               end else if (req_symbol == bdt_pkg::SYM_RIGHT) begin
                  if (cursor_ff != bdt_pkg::CURSOR_MAX) begin
                     cursor_in = cursor_ff + bdt_pkg::CUR_W'(1);
                  end
                  state_in = ST_DONE;
               end else begin
                  weight_in = bdt_pkg::sym_weight(req_symbol);
                  ram_re    = 1'b1;
                  ram_raddr = leaf_idx;
                  state_in  = ST_LEAF;
               end
            end
         end
         ST_LEAF: begin
            // unchanged kind leaves the tree alone
            if (rd_node.total == weight_ff) begin
               state_in = ST_DONE;
            end else begin
               ram_we      = 1'b1;
               ram_waddr   = leaf_idx;
               ram_wdata   = leaf_node;
               cur_in      = leaf_node;
               node_idx_in = leaf_idx;
               ram_re      = 1'b1;
               ram_raddr   = leaf_idx ^ bdt_pkg::IDX_W'(1);
               state_in    = ST_WALK;
            end
         end
         ST_WALK: begin
            // sibling is in rd_node; write parent, fetch the next sibling below the root
            ram_we    = 1'b1;
            ram_waddr = par_idx;
            ram_wdata = parent;
            if (par_idx == bdt_pkg::IDX_W'(1)) begin
               root_in  = parent;
               state_in = ST_DONE;
            end else begin
               cur_in      = parent;
               node_idx_in = par_idx;
               ram_re      = 1'b1;
               ram_raddr   = par_idx ^ bdt_pkg::IDX_W'(1);
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = answer;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         cursor_ff    <= '0;
         clear_ff     <= '0;
         root_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cursor_ff    <= cursor_in;
         clear_ff     <= clear_in;
         root_ff      <= root_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      node_idx_ff <= node_idx_in;
      weight_ff   <= weight_in;
      cur_ff      <= cur_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_stall         = (state_ff != ST_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_depth_or_fail = rsp_data_ff;

endmodule

`default_nettype wire

@@ test/tb_bracket_editor_depth_tracker.sv @@
// Testbench for bracket_editor_depth_tracker: editor commands in, nesting depth out.
// Checks every result word against an in-bench line predictor; depends on bdt_pkg
// and the RTL top level only.
`timescale 1ns / 1ps

module tb_bracket_editor_depth_tracker;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             req_valid = 1'b0;
   logic                             req_stall;
   logic [7:0]                       req_symbol = 8'h00;
   logic                             rsp_valid;
   logic                             rsp_stall = 1'b0;
   logic signed [bdt_pkg::VAL_W-1:0] rsp_depth_or_fail;

   // Predictor state: nonzero cell weights only, the cursor, and pending depths
   int                               cell_weight[int];
   int                               edit_cursor = 0;
   logic signed [bdt_pkg::VAL_W-1:0] depth_queue[$];
   int                               mismatch_count = 0;
   int                               sent_count = 0;
   bit                               steady = 1'b0;

   bracket_editor_depth_tracker u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_symbol        (req_symbol),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_depth_or_fail (rsp_depth_or_fail)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Hard stop: clearing pass and all edits, several times over
   initial begin
      #300_000_000;
      $display("*** FAILED ***");
      $finish;
   end

   // Receiver back-pressure
   always @(posedge clock) begin
      rsp_stall <= !steady && ($urandom_range(0, 99) < 31);
   end

   // Depth of the whole line, or -1 when unbalanced
   function automatic logic signed [bdt_pkg::VAL_W-1:0] line_depth();
      int level;
      int lowest;
      int highest;
      level   = 0;
      lowest  = 0;
      highest = 0;
      foreach (cell_weight[pos]) begin
         level += cell_weight[pos];
         if (level < lowest) lowest = level;
         if (level > highest) highest = level;
      end
      if (level != 0 || lowest < 0) return '1;
      return bdt_pkg::VAL_W'(highest);
   endfunction

   // Any byte that is neither a bracket nor a cursor move
   function automatic logic [7:0] neutral_byte();
      logic [7:0] b;
      do begin
         b = 8'($urandom_range(0, 255));
      end while (b == bdt_pkg::SYM_OPEN || b == bdt_pkg::SYM_CLOSE ||
                 b == bdt_pkg::SYM_LEFT || b == bdt_pkg::SYM_RIGHT);
      return b;
   endfunction

   // Advance the predictor by one accepted command
   task automatic apply_command(input logic [7:0] sym);
      int w;
      case (sym)
         bdt_pkg::SYM_LEFT: begin
            if (edit_cursor > 0) edit_cursor--;
         end
         bdt_pkg::SYM_RIGHT: begin
            if (edit_cursor < bdt_pkg::LENGTH - 1) edit_cursor++;
         end
         default: begin
            w = (sym == bdt_pkg::SYM_OPEN) ? 1 : (sym == bdt_pkg::SYM_CLOSE) ? -1 : 0;
            if (w == 0) cell_weight.delete(edit_cursor);
            else cell_weight[edit_cursor] = w;
         end
      endcase
      depth_queue.push_back(line_depth());
   endtask

   // Send one command word, with random idle cycles ahead of it
   task automatic send_symbol(input logic [7:0] sym);
      while (!steady && $urandom_range(0, 99) < 31) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_symbol <= sym;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      apply_command(sym);
      sent_count++;
   endtask

   task automatic move_to(input int target);
      while (edit_cursor > target) send_symbol(bdt_pkg::SYM_LEFT);
      while (edit_cursor < target) send_symbol(bdt_pkg::SYM_RIGHT);
   endtask

   task automatic erase_cell(input int pos);
      move_to(pos);
      send_symbol(neutral_byte());
   endtask

   // Neutralize every bracket on the line
   task automatic erase_all();
      int spots[$];
      foreach (cell_weight[pos]) spots.push_back(pos);
      foreach (spots[i]) erase_cell(spots[i]);
   endtask

   // Random editing in a 96-cell window: mostly balanced strings, plus noise
   task automatic random_edits(input int count, input int window_lo);
      int         stop_at;
      int         mode;
      int         k;
      int         opened;
      int         closed;
      int         start;
      int         n;
      int         spots[$];
      logic [7:0] ch;
      stop_at = sent_count + count;
      while (sent_count < stop_at) begin
         mode = $urandom_range(0, 99);
         if (mode < 12) begin
            erase_all();
         end else if (mode < 60) begin
            // balanced string, sometimes deep, sometimes with neutral filler
            k = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 20) : $urandom_range(1, 6);
            start = window_lo + $urandom_range(0, 96 - 4 * k);
            move_to(start);
            opened = 0;
            closed = 0;
            while (closed < k) begin
               if (opened < k && (opened == closed || $urandom_range(0, 1) == 1)) begin
                  ch = bdt_pkg::SYM_OPEN;
                  opened++;
               end else begin
                  ch = bdt_pkg::SYM_CLOSE;
                  closed++;
               end
               if (k <= 6 && $urandom_range(0, 9) == 0) begin
                  send_symbol(neutral_byte());
                  send_symbol(bdt_pkg::SYM_RIGHT);
               end
               send_symbol(ch);
               send_symbol(bdt_pkg::SYM_RIGHT);
            end
            // break it now and then
            if ($urandom_range(0, 4) == 0) begin
               move_to(start + $urandom_range(0, 2 * k - 1));
               case ($urandom_range(0, 2))
                  0: send_symbol(bdt_pkg::SYM_OPEN);
                  1: send_symbol(bdt_pkg::SYM_CLOSE);
                  default: send_symbol(neutral_byte());
               endcase
            end
         end else if (mode < 82) begin
            // loose commands, any byte
            n = $urandom_range(1, 6);
            repeat (n) begin
               k = $urandom_range(0, 99);
               if (k < 20) send_symbol(bdt_pkg::SYM_LEFT);
               else if (k < 40) send_symbol(bdt_pkg::SYM_RIGHT);
               else if (k < 55) send_symbol(bdt_pkg::SYM_OPEN);
               else if (k < 70) send_symbol(bdt_pkg::SYM_CLOSE);
               else send_symbol(8'($urandom_range(0, 255)));
            end
         end else if (cell_weight.num() > 0) begin
            spots.delete();
            foreach (cell_weight[pos]) spots.push_back(pos);
            erase_cell(spots[$urandom_range(0, spots.size() - 1)]);
         end
      end
   endtask

   // Left edge, same-kind rewrites, byte extremes, short balanced lines
   task automatic test_left_edge();
      send_symbol(bdt_pkg::SYM_LEFT);
      send_symbol(8'h00);
      send_symbol(bdt_pkg::SYM_OPEN);
      send_symbol(bdt_pkg::SYM_OPEN);
      send_symbol(bdt_pkg::SYM_RIGHT);
      send_symbol(bdt_pkg::SYM_CLOSE);
      send_symbol(bdt_pkg::SYM_RIGHT);
      send_symbol(8'hFF);
      send_symbol(bdt_pkg::SYM_LEFT);
      send_symbol(bdt_pkg::SYM_LEFT);
      send_symbol(bdt_pkg::SYM_LEFT);
      send_symbol(bdt_pkg::SYM_CLOSE);
      send_symbol(bdt_pkg::SYM_OPEN);
      send_symbol(8'h61);
      send_symbol(bdt_pkg::SYM_OPEN);
      send_symbol(bdt_pkg::SYM_RIGHT);
      send_symbol(bdt_pkg::SYM_RIGHT);
      send_symbol(bdt_pkg::SYM_OPEN);
      send_symbol(bdt_pkg::SYM_RIGHT);
      send_symbol(bdt_pkg::SYM_CLOSE);
      send_symbol(bdt_pkg::SYM_LEFT);
      send_symbol(bdt_pkg::SYM_LEFT);
      send_symbol(bdt_pkg::SYM_OPEN);
      send_symbol(8'h80);
      send_symbol(8'h7F);
   endtask

   // Random editing near the start, with a stretch of no idling on either side
   task automatic test_random_edits();
      random_edits(130, 0);
      steady = 1'b1;
      random_edits(120, 0);
      steady = 1'b0;
      random_edits(130, 0);
   endtask

   // Empty the line, then lone closes and opens around the cursor, then more edits
   task automatic test_clean_line();
      erase_all();
      send_symbol(bdt_pkg::SYM_RIGHT);
      send_symbol(bdt_pkg::SYM_RIGHT);
      send_symbol(bdt_pkg::SYM_CLOSE);
      send_symbol(bdt_pkg::SYM_LEFT);
      send_symbol(bdt_pkg::SYM_OPEN);
      send_symbol(bdt_pkg::SYM_RIGHT);
      send_symbol(bdt_pkg::SYM_CLOSE);
      send_symbol(bdt_pkg::SYM_OPEN);
      send_symbol(bdt_pkg::SYM_CLOSE);
      send_symbol(8'h5A);
      send_symbol(bdt_pkg::SYM_CLOSE);
      send_symbol(bdt_pkg::SYM_RIGHT);
      random_edits(120, 0);
   endtask

   // Result checker: each accepted word against the oldest pending depth
   always @(posedge clock) begin : check_result
      logic signed [bdt_pkg::VAL_W-1:0] want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (depth_queue.size() == 0) begin
            $display("%0t: unexpected result word, expected none, actual %0d",
                     $time, rsp_depth_or_fail);
            mismatch_count++;
         end else begin
            want = depth_queue.pop_front();
            if (rsp_depth_or_fail !== want) begin
               $display("%0t: depth_or_fail mismatch, expected %0d, actual %0d",
                        $time, want, rsp_depth_or_fail);
               mismatch_count++;
            end
         end
      end
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      test_left_edge();
      test_random_edits();
      test_clean_line();
      req_valid <= 1'b0;
      while (depth_queue.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
